// ===== rtl/xbts_pkg.sv =====
// Shared types and constants of the x86 16-bit branch target scanner.
// No dependencies; every other file of the block imports this package.
package xbts_pkg;

  localparam int BYTE_W          = 8;
  localparam int LABEL_W         = 16;
  localparam int SIZE_W          = 17;
  localparam int POS_W           = 17;
  localparam int SKIP_W          = 3;
  localparam int TRAIL_W         = 2;
  localparam int ROW_SEL_W       = 5;   // bitmap row holds 2**ROW_SEL_W marks
  localparam int DEF_ADDR_WIDTH  = 16;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 17'h10000;

  // Decoder phase within one instruction
  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_GROUP   = 3'd2,
    PH_SKIP    = 3'd3,
    PH_SHORT   = 3'd4,
    PH_NEAR_LO = 3'd5,
    PH_NEAR_HI = 3'd6
  } phase_t;

  // Length-tracking state of the decoder
  typedef struct packed {
    phase_t              phase;
    logic [SKIP_W-1:0]   skip;
    logic [TRAIL_W-1:0]  trail;
    logic                gwide;
    logic [BYTE_W-1:0]   disp_low;
  } dec_state_t;

endpackage

// ===== rtl/xbts_if.sv =====
// Valid/ready channel interfaces for the branch target scanner.
// Depends on xbts_pkg for the payload widths.
interface xbts_byte_if import xbts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface xbts_label_if import xbts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label_address;

  modport source (output valid, output label_address, input ready);
  modport sink   (input valid, input label_address, output ready);
endinterface

// ===== rtl/xbts_decoder.sv =====
// Instruction length tracker: follows 8086 instruction boundaries byte by byte
// and computes relative branch targets. Depends on xbts_pkg.
module xbts_decoder import xbts_pkg::*; #(
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [BYTE_W-1:0]     code_byte,
  input  logic [SIZE_W-1:0]     image_size,
  output logic                  cand_valid,
  output logic [ADDR_WIDTH-1:0] cand_addr
);

  // Target arithmetic width: sign plus enough magnitude for position +- 32K
  localparam int TW = (ADDR_WIDTH + 1 > 19) ? ADDR_WIDTH + 1 : 19;

  localparam logic [BYTE_W-1:0] OP_LOW_ALU_END = 8'h40;
  localparam logic [BYTE_W-1:0] OP_JCC_FIRST   = 8'h70;
  localparam logic [BYTE_W-1:0] OP_JCC_LAST    = 8'h7F;
  localparam logic [BYTE_W-1:0] OP_GRP1_FIRST  = 8'h80;
  localparam logic [BYTE_W-1:0] OP_GRP1_LAST   = 8'h83;
  localparam logic [BYTE_W-1:0] OP_MODRM_FIRST = 8'h84;
  localparam logic [BYTE_W-1:0] OP_MODRM_LAST  = 8'h8F;
  localparam logic [BYTE_W-1:0] OP_CALL_FAR    = 8'h9A;
  localparam logic [BYTE_W-1:0] OP_JMP_FAR     = 8'hEA;
  localparam logic [BYTE_W-1:0] OP_MOV_MEM_LO  = 8'hA0;
  localparam logic [BYTE_W-1:0] OP_MOV_MEM_HI  = 8'hA3;
  localparam logic [BYTE_W-1:0] OP_TEST_AL     = 8'hA8;
  localparam logic [BYTE_W-1:0] OP_TEST_AX     = 8'hA9;
  localparam logic [BYTE_W-1:0] OP_MOV_IMM_LO  = 8'hB0;
  localparam logic [BYTE_W-1:0] OP_MOV_IMM_HI  = 8'hBF;
  localparam logic [BYTE_W-1:0] OP_RET_IMM     = 8'hC2;
  localparam logic [BYTE_W-1:0] OP_RETF_IMM    = 8'hCA;
  localparam logic [BYTE_W-1:0] OP_LES         = 8'hC4;
  localparam logic [BYTE_W-1:0] OP_LDS         = 8'hC5;
  localparam logic [BYTE_W-1:0] OP_MOV_RM_B    = 8'hC6;
  localparam logic [BYTE_W-1:0] OP_MOV_RM_W    = 8'hC7;
  localparam logic [BYTE_W-1:0] OP_INT         = 8'hCD;
  localparam logic [BYTE_W-1:0] OP_AAM         = 8'hD4;
  localparam logic [BYTE_W-1:0] OP_AAD         = 8'hD5;
  localparam logic [BYTE_W-1:0] OP_SHIFT_FIRST = 8'hD0;
  localparam logic [BYTE_W-1:0] OP_SHIFT_LAST  = 8'hD3;
  localparam logic [BYTE_W-1:0] OP_ESC_FIRST   = 8'hD8;
  localparam logic [BYTE_W-1:0] OP_ESC_LAST    = 8'hDF;
  localparam logic [BYTE_W-1:0] OP_LOOP_FIRST  = 8'hE0;
  localparam logic [BYTE_W-1:0] OP_LOOP_LAST   = 8'hE3;
  localparam logic [BYTE_W-1:0] OP_IO_FIRST    = 8'hE4;
  localparam logic [BYTE_W-1:0] OP_IO_LAST     = 8'hE7;
  localparam logic [BYTE_W-1:0] OP_CALL_NEAR   = 8'hE8;
  localparam logic [BYTE_W-1:0] OP_JMP_NEAR    = 8'hE9;
  localparam logic [BYTE_W-1:0] OP_JMP_SHORT   = 8'hEB;
  localparam logic [BYTE_W-1:0] OP_GRP3_B      = 8'hF6;
  localparam logic [BYTE_W-1:0] OP_GRP3_W      = 8'hF7;
  localparam logic [BYTE_W-1:0] OP_GRP45_B     = 8'hFE;
  localparam logic [BYTE_W-1:0] OP_GRP45_W     = 8'hFF;

  dec_state_t         st, st_next;
  logic [POS_W-1:0]   byte_position;
  logic               step;
  logic [TW-1:0]      rel;
  logic [TW-1:0]      tgt;
  logic               is_branch;

  // Skip n operand bytes, then any pending immediate
  function automatic dec_state_t begin_skip(dec_state_t s, logic [SKIP_W-1:0] n);
    dec_state_t        r;
    logic [SKIP_W-1:0] k;
    r = s;
    k = n;
    if (k == '0) begin
      k = SKIP_W'(s.trail);
      r.trail = '0;
    end
    if (k == '0) begin
      r.phase = PH_OPCODE;
    end else begin
      r.skip  = k;
      r.phase = PH_SKIP;
    end
    return r;
  endfunction

  // Displacement bytes implied by a ModRM byte
  function automatic logic [SKIP_W-1:0] modrm_disp(logic [BYTE_W-1:0] m);
    logic [SKIP_W-1:0] d;
    d = '0;
    if (m[7:6] == 2'd0 && m[2:0] == 3'd6) d = SKIP_W'(2);
    else if (m[7:6] == 2'd1)              d = SKIP_W'(1);
    else if (m[7:6] == 2'd2)              d = SKIP_W'(2);
    return d;
  endfunction

  // Opcode length rules
  function automatic dec_state_t decode_opcode(dec_state_t s, logic [BYTE_W-1:0] op);
    dec_state_t        r;
    logic [SKIP_W-1:0] wsz;
    r = s;
    r.trail = '0;
    wsz = op[0] ? SKIP_W'(2) : SKIP_W'(1);
    if (op < OP_LOW_ALU_END && op[2:0] < 3'd4) begin
      r.phase = PH_MODRM;
    end else if (op < OP_LOW_ALU_END && op[2:0] < 3'd6) begin
      r = begin_skip(r, wsz);
    end else if (op >= OP_JCC_FIRST && op <= OP_JCC_LAST) begin
      r.phase = PH_SHORT;
    end else if (op >= OP_GRP1_FIRST && op <= OP_GRP1_LAST) begin
      r.trail = (op[1:0] == 2'd1) ? TRAIL_W'(2) : TRAIL_W'(1);
      r.phase = PH_MODRM;
    end else if (op >= OP_MODRM_FIRST && op <= OP_MODRM_LAST) begin
      r.phase = PH_MODRM;
    end else if (op == OP_CALL_FAR || op == OP_JMP_FAR) begin
      r = begin_skip(r, SKIP_W'(4));
    end else if (op >= OP_MOV_MEM_LO && op <= OP_MOV_MEM_HI) begin
      r = begin_skip(r, SKIP_W'(2));
    end else if (op == OP_TEST_AL || op == OP_TEST_AX) begin
      r = begin_skip(r, wsz);
    end else if (op >= OP_MOV_IMM_LO && op <= OP_MOV_IMM_HI) begin
      r = begin_skip(r, op[3] ? SKIP_W'(2) : SKIP_W'(1));
    end else if (op == OP_RET_IMM || op == OP_RETF_IMM) begin
      r = begin_skip(r, SKIP_W'(2));
    end else if (op == OP_LES || op == OP_LDS) begin
      r.phase = PH_MODRM;
    end else if (op == OP_MOV_RM_B || op == OP_MOV_RM_W) begin
      r.trail = op[0] ? TRAIL_W'(2) : TRAIL_W'(1);
      r.phase = PH_MODRM;
    end else if (op == OP_INT || op == OP_AAM || op == OP_AAD) begin
      r = begin_skip(r, SKIP_W'(1));
    end else if (op >= OP_SHIFT_FIRST && op <= OP_SHIFT_LAST) begin
      r.phase = PH_MODRM;
    end else if (op >= OP_ESC_FIRST && op <= OP_ESC_LAST) begin
      r.phase = PH_MODRM;
    end else if (op >= OP_LOOP_FIRST && op <= OP_LOOP_LAST) begin
      r.phase = PH_SHORT;
    end else if (op >= OP_IO_FIRST && op <= OP_IO_LAST) begin
      r = begin_skip(r, SKIP_W'(1));
    end else if (op == OP_CALL_NEAR || op == OP_JMP_NEAR) begin
      r.phase = PH_NEAR_LO;
    end else if (op == OP_JMP_SHORT) begin
      r.phase = PH_SHORT;
    end else if (op == OP_GRP3_B || op == OP_GRP3_W) begin
      r.gwide = op[0];
      r.phase = PH_GROUP;
    end else if (op == OP_GRP45_B || op == OP_GRP45_W) begin
      r.phase = PH_MODRM;
    end else begin
      r.phase = PH_OPCODE;
    end
    return r;
  endfunction

  // Bytes at or past the image end leave everything untouched
  assign step = accept && (byte_position < image_size);

  // Next state of the length tracker
  always_comb begin
    dec_state_t tmp;
    tmp = st;
    st_next = st;
    if (step) begin
      case (st.phase)
        PH_OPCODE: begin
          st_next = decode_opcode(st, code_byte);
        end
        PH_MODRM: begin
          st_next = begin_skip(st, modrm_disp(code_byte));
        end
        PH_GROUP: begin
          // TEST (reg field zero) carries an immediate
          if (code_byte[5:3] == 3'd0) tmp.trail = st.gwide ? TRAIL_W'(2) : TRAIL_W'(1);
          else                        tmp.trail = '0;
          st_next = begin_skip(tmp, modrm_disp(code_byte));
        end
        PH_SKIP: begin
          tmp.skip = st.skip - SKIP_W'(1);
          if (tmp.skip == '0) st_next = begin_skip(tmp, '0);
          else                st_next = tmp;
        end
        PH_NEAR_LO: begin
          st_next.disp_low = code_byte;
          st_next.phase    = PH_NEAR_HI;
        end
        PH_SHORT, PH_NEAR_HI: begin
          st_next.phase = PH_OPCODE;
        end
        default: begin
          st_next.phase = PH_OPCODE;
        end
      endcase
    end
  end

  // Target of a relative branch: next instruction address plus displacement
  always_comb begin
    is_branch = (st.phase == PH_SHORT) || (st.phase == PH_NEAR_HI);
    if (st.phase == PH_NEAR_HI) rel = TW'($signed({code_byte, st.disp_low}));
    else                        rel = TW'($signed(code_byte));
    tgt = TW'(byte_position) + TW'(1) + rel;
    cand_valid = step && is_branch && !tgt[TW-1] && (tgt < TW'(image_size)) &&
                 ((tgt >> ADDR_WIDTH) == '0);
    cand_addr  = tgt[ADDR_WIDTH-1:0];
  end

  // Hold decoder state; advance position on in-image bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_OPCODE;
      st.skip       <= '0;
      st.trail      <= '0;
      st.gwide      <= 1'b0;
      st.disp_low   <= '0;
      byte_position <= '0;
    end else begin
      st <= st_next;
      if (step) byte_position <= byte_position + POS_W'(1);
    end
  end

endmodule

// ===== rtl/xbts_label_map.sv =====
// Label bitmap: one mark per image address in a synchronous memory, with a
// read-modify-write stage and the result register. Depends on xbts_pkg.
module xbts_label_map import xbts_pkg::*; #(
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cand_valid,
  input  logic [ADDR_WIDTH-1:0] cand_addr,
  output logic                  accept_ok,
  output logic                  clearing,
  xbts_label_if.source          label
);

  localparam int ROW_W    = ADDR_WIDTH - ROW_SEL_W;
  localparam int ROWS     = 1 << ROW_W;
  localparam int ROW_BITS = 1 << ROW_SEL_W;

  logic [ROW_BITS-1:0]  mem [ROWS];
  logic [ROW_BITS-1:0]  rd_data;
  logic [ROW_W-1:0]     clr_row;
  logic                 s1_valid;
  logic [ROW_W-1:0]     s1_row;
  logic [ROW_SEL_W-1:0] s1_col;
  logic                 s1_go;
  logic                 s1_hit;
  logic                 s1_mark;
  logic [ROW_W-1:0]     cand_row;

  assign cand_row = cand_addr[ADDR_WIDTH-1:ROW_SEL_W];
  assign s1_hit   = rd_data[s1_col];
  // Resolve the pending lookup once the result register can take a beat
  assign s1_go    = s1_valid && (!label.valid || label.ready);
  assign s1_mark  = s1_go && !s1_hit;
  // Interlock: no new byte while the lookup holds, so reads never race writes
  assign accept_ok = !clearing && !(s1_valid && !s1_go);

  // Memory: read the candidate row, write the clear sweep or the new mark
  always_ff @(posedge clk) begin
    if (cand_valid) rd_data <= mem[cand_row];
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (s1_mark) begin
      mem[s1_row] <= rd_data | (ROW_BITS'(1) << s1_col);
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk) begin
    if (cand_valid) begin
      s1_row <= cand_row;
      s1_col <= cand_addr[ROW_SEL_W-1:0];
    end
    if (s1_mark) label.label_address <= LABEL_W'({s1_row, s1_col});
  end

  // Control: clear sweep, lookup valid, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_row     <= '0;
      s1_valid    <= 1'b0;
      label.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + ROW_W'(1);
        if (clr_row == ROW_W'(ROWS - 1)) clearing <= 1'b0;
      end
      if (cand_valid)  s1_valid <= 1'b1;
      else if (s1_go)  s1_valid <= 1'b0;
      if (s1_mark)          label.valid <= 1'b1;
      else if (label.ready) label.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/x86_16_branch_target_scanner.sv =====
// Top level of the x86 16-bit branch target scanner: image size register,
// length decoder and label bitmap. Depends on xbts_pkg, xbts_if,
// xbts_decoder and xbts_label_map.
//
// Usage: stream the code image one byte per beat on the code channel, in
// address order from address 0. The label channel carries one beat for each
// branch target (8-bit Jcc/LOOP/JMP short, 16-bit CALL/JMP near) that lies
// inside the image and has not been reported before. Bytes past image_size
// are taken and ignored. Write image_size (cfg_wr_en, cfg_wr_data) only while
// the block is idle.
// Throughput: one code byte per cycle, except during the reset sweep or while a
// target lookup waits behind an untaken result. Path: a target found on the beat
// carrying the branch's last displacement byte passes the bitmap read register,
// then the mark write and the result register, where it waits while it is untaken.
// Reset: the bitmap is swept clear one 32-mark row per cycle, 2**(ADDR_WIDTH-5)
// rows (2048 by default); code.ready stays low during the sweep.
// Stall: a waiting result does not block input; code.ready drops only during the
// reset sweep or when a second target lookup is pending behind an untaken result.
module x86_16_branch_target_scanner import xbts_pkg::*; #(
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  xbts_byte_if.sink         code,
  xbts_label_if.source      label
);

  localparam int CMP_W = (ADDR_WIDTH > SIZE_W) ? ADDR_WIDTH : SIZE_W;

  logic [SIZE_W-1:0]     image_size;
  logic                  accept_ok;
  logic                  clearing;
  logic                  cand_valid;
  logic [ADDR_WIDTH-1:0] cand_addr;

  // Image size register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= IMAGE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      image_size <= cfg_wr_data;
    end
  end

  assign code.ready = accept_ok;

  xbts_decoder #(.ADDR_WIDTH(ADDR_WIDTH)) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .accept     (code.valid && code.ready),
    .code_byte  (code.code_byte),
    .image_size (image_size),
    .cand_valid (cand_valid),
    .cand_addr  (cand_addr)
  );

  xbts_label_map #(.ADDR_WIDTH(ADDR_WIDTH)) u_label_map (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_addr  (cand_addr),
    .accept_ok  (accept_ok),
    .clearing   (clearing),
    .label      (label)
  );

  // No result while the bitmap is being cleared
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !label.valid)
    else $error("label beat during bitmap sweep");

  // A lookup only issues for a target inside the image
  a_target_in_image: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> (CMP_W'(cand_addr) < CMP_W'(image_size)))
    else $error("target lookup outside the image");

  // Lookups never come back to back, so a read never meets a same-row write
  a_lookup_spacing: assert property (@(posedge clk) disable iff (rst)
    cand_valid |=> !cand_valid)
    else $error("back-to-back bitmap lookups");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the x86 16-bit branch target scanner: streams code bytes,
// mirrors the length decoder and label bitmap, and checks every reported label.
// Depends on xbts_pkg, xbts_if and the x86_16_branch_target_scanner top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xbts_pkg::*;

  // Opcodes and opcode ranges that the decoder tells apart
  localparam logic [7:0] OP_ALU_LIMIT     = 8'h40;
  localparam logic [7:0] OP_JCC_LO        = 8'h70;
  localparam logic [7:0] OP_JCC_HI        = 8'h7F;
  localparam logic [7:0] OP_IMM_GRP_LO    = 8'h80;
  localparam logic [7:0] OP_IMM_GRP_HI    = 8'h83;
  localparam logic [7:0] OP_MODRM_LO      = 8'h84;
  localparam logic [7:0] OP_MODRM_HI      = 8'h8F;
  localparam logic [7:0] OP_NOP           = 8'h90;
  localparam logic [7:0] OP_CALL_FAR      = 8'h9A;
  localparam logic [7:0] OP_MOV_MOFFS_LO  = 8'hA0;
  localparam logic [7:0] OP_MOV_MOFFS_HI  = 8'hA3;
  localparam logic [7:0] OP_TEST_ACC_B    = 8'hA8;
  localparam logic [7:0] OP_TEST_ACC_W    = 8'hA9;
  localparam logic [7:0] OP_MOV_IMM_LO    = 8'hB0;
  localparam logic [7:0] OP_MOV_IMM_HI    = 8'hBF;
  localparam logic [7:0] OP_RET_IMM       = 8'hC2;
  localparam logic [7:0] OP_RET           = 8'hC3;
  localparam logic [7:0] OP_LES           = 8'hC4;
  localparam logic [7:0] OP_LDS           = 8'hC5;
  localparam logic [7:0] OP_MOV_RM_IMM_B  = 8'hC6;
  localparam logic [7:0] OP_MOV_RM_IMM_W  = 8'hC7;
  localparam logic [7:0] OP_RETF_IMM      = 8'hCA;
  localparam logic [7:0] OP_INT           = 8'hCD;
  localparam logic [7:0] OP_SHIFT_LO      = 8'hD0;
  localparam logic [7:0] OP_SHIFT_HI      = 8'hD3;
  localparam logic [7:0] OP_AAM           = 8'hD4;
  localparam logic [7:0] OP_AAD           = 8'hD5;
  localparam logic [7:0] OP_ESC_LO        = 8'hD8;
  localparam logic [7:0] OP_ESC_HI        = 8'hDF;
  localparam logic [7:0] OP_LOOP_LO       = 8'hE0;
  localparam logic [7:0] OP_LOOP_HI       = 8'hE3;
  localparam logic [7:0] OP_IO_IMM_LO     = 8'hE4;
  localparam logic [7:0] OP_IO_IMM_HI     = 8'hE7;
  localparam logic [7:0] OP_CALL_NEAR     = 8'hE8;
  localparam logic [7:0] OP_JMP_NEAR      = 8'hE9;
  localparam logic [7:0] OP_JMP_FAR       = 8'hEA;
  localparam logic [7:0] OP_JMP_SHORT     = 8'hEB;
  localparam logic [7:0] OP_GRP3_B        = 8'hF6;
  localparam logic [7:0] OP_GRP3_W        = 8'hF7;
  localparam logic [7:0] OP_GRP45_B       = 8'hFE;
  localparam logic [7:0] OP_GRP45_W       = 8'hFF;
  localparam logic [2:0] RM_DIRECT        = 3'd6;
  localparam logic [2:0] REG_TEST         = 3'd0;
  localparam int         MAP_SIZE         = 1 << DEF_ADDR_WIDTH;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         MAX_REPORTS      = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  xbts_byte_if  code_if ();
  xbts_label_if label_if ();

  x86_16_branch_target_scanner dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .code        (code_if),
    .label       (label_if)
  );

  // Mirror of the decoder state and the label bitmap
  logic [SIZE_W-1:0] img_size  = IMAGE_SIZE_RESET;
  logic [POS_W-1:0]  pos       = '0;
  phase_t            ph        = PH_OPCODE;
  logic [2:0]        skip_cnt  = '0;
  logic [1:0]        trail_imm = '0;
  logic              group_w   = 1'b0;
  logic [7:0]        disp_lo   = '0;
  bit                label_seen [0:MAP_SIZE-1];
  logic [LABEL_W-1:0] expected_labels [$];

  int err_cnt      = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Drive label ready with random stalls
  always @(posedge clk) begin
    label_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each label beat with the oldest predicted label
  always @(posedge clk) begin
    logic [LABEL_W-1:0] want;
    if (!rst && label_if.valid && label_if.ready) begin
      if (expected_labels.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected label %h", label_if.label_address);
        err_cnt++;
      end else begin
        want = expected_labels.pop_front();
        if (label_if.label_address !== want) begin
          if (err_cnt < MAX_REPORTS)
            $display("label mismatch: expected %h got %h", want, label_if.label_address);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [2:0] modrm_disp_len(input logic [7:0] m);
    if (m[7:6] == 2'd0 && m[2:0] == RM_DIRECT) return 3'd2;
    if (m[7:6] == 2'd1) return 3'd1;
    if (m[7:6] == 2'd2) return 3'd2;
    return 3'd0;
  endfunction

  // Skip n operand bytes, then any pending immediate
  task automatic start_skip(input logic [2:0] n);
    logic [2:0] k;
    k = n;
    if (k == 3'd0) begin
      k = {1'b0, trail_imm};
      trail_imm = 2'd0;
    end
    if (k == 3'd0) begin
      ph = PH_OPCODE;
    end else begin
      skip_cnt = k;
      ph = PH_SKIP;
    end
  endtask

  // Mark a branch target and queue it when it is new and inside the image
  task automatic record_target(input int t);
    if (t < 0 || t >= int'(img_size) || t >= MAP_SIZE) return;
    if (label_seen[t]) return;
    label_seen[t] = 1'b1;
    expected_labels.push_back(t[LABEL_W-1:0]);
  endtask

  task automatic decode_opcode(input logic [7:0] op);
    trail_imm = 2'd0;
    if (op < OP_ALU_LIMIT && op[2:0] < 3'd4) begin
      ph = PH_MODRM;
    end else if (op < OP_ALU_LIMIT && op[2:0] < 3'd6) begin
      start_skip(op[0] ? 3'd2 : 3'd1);
    end else if (op >= OP_JCC_LO && op <= OP_JCC_HI) begin
      ph = PH_SHORT;
    end else if (op >= OP_IMM_GRP_LO && op <= OP_IMM_GRP_HI) begin
      trail_imm = (op[1:0] == 2'd1) ? 2'd2 : 2'd1;
      ph = PH_MODRM;
    end else if (op >= OP_MODRM_LO && op <= OP_MODRM_HI) begin
      ph = PH_MODRM;
    end else if (op == OP_CALL_FAR || op == OP_JMP_FAR) begin
      start_skip(3'd4);
    end else if (op >= OP_MOV_MOFFS_LO && op <= OP_MOV_MOFFS_HI) begin
      start_skip(3'd2);
    end else if (op == OP_TEST_ACC_B || op == OP_TEST_ACC_W) begin
      start_skip(op[0] ? 3'd2 : 3'd1);
    end else if (op >= OP_MOV_IMM_LO && op <= OP_MOV_IMM_HI) begin
      start_skip(op[3] ? 3'd2 : 3'd1);
    end else if (op == OP_RET_IMM || op == OP_RETF_IMM) begin
      start_skip(3'd2);
    end else if (op == OP_LES || op == OP_LDS) begin
      ph = PH_MODRM;
    end else if (op == OP_MOV_RM_IMM_B || op == OP_MOV_RM_IMM_W) begin
      trail_imm = op[0] ? 2'd2 : 2'd1;
      ph = PH_MODRM;
    end else if (op == OP_INT || op == OP_AAM || op == OP_AAD) begin
      start_skip(3'd1);
    end else if ((op >= OP_SHIFT_LO && op <= OP_SHIFT_HI) ||
                 (op >= OP_ESC_LO && op <= OP_ESC_HI)) begin
      ph = PH_MODRM;
    end else if (op >= OP_LOOP_LO && op <= OP_LOOP_HI) begin
      ph = PH_SHORT;
    end else if (op >= OP_IO_IMM_LO && op <= OP_IO_IMM_HI) begin
      start_skip(3'd1);
    end else if (op == OP_CALL_NEAR || op == OP_JMP_NEAR) begin
      ph = PH_NEAR_LO;
    end else if (op == OP_JMP_SHORT) begin
      ph = PH_SHORT;
    end else if (op == OP_GRP3_B || op == OP_GRP3_W) begin
      group_w = op[0];
      ph = PH_GROUP;
    end else if (op == OP_GRP45_B || op == OP_GRP45_W) begin
      ph = PH_MODRM;
    end else begin
      ph = PH_OPCODE;
    end
  endtask

  // Advance the mirrored decoder by one accepted code byte
  task automatic advance_decoder(input logic [7:0] b);
    logic [POS_W-1:0] at;
    int rel;
    at = pos;
    if (at >= img_size) return;
    pos = at + POS_W'(1);
    case (ph)
      PH_OPCODE: decode_opcode(b);
      PH_MODRM:  start_skip(modrm_disp_len(b));
      PH_GROUP: begin
        trail_imm = (b[5:3] == REG_TEST) ? (group_w ? 2'd2 : 2'd1) : 2'd0;
        start_skip(modrm_disp_len(b));
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 3'd1;
        if (skip_cnt == 3'd0) start_skip(3'd0);
      end
      PH_SHORT: begin
        rel = int'($signed(b));
        record_target(int'(at) + 1 + rel);
        ph = PH_OPCODE;
      end
      PH_NEAR_LO: begin
        disp_lo = b;
        ph = PH_NEAR_HI;
      end
      PH_NEAR_HI: begin
        rel = int'($signed({b, disp_lo}));
        record_target(int'(at) + 1 + rel);
        ph = PH_OPCODE;
      end
      default: ph = PH_OPCODE;
    endcase
  endtask

  // Offer one code byte, hold it until the beat is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      code_if.valid <= 1'b0;
      @(posedge clk);
    end
    code_if.valid     <= 1'b1;
    code_if.code_byte <= b;
    @(posedge clk);
    while (!code_if.ready) @(posedge clk);
    advance_decoder(b);
  endtask

  // Drop valid and wait until every predicted label has come out
  task automatic settle();
    code_if.valid <= 1'b0;
    while (expected_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [SIZE_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    img_size = v;
  endtask

  // Empty image: every byte is ignored and the position stays at zero
  task automatic test_empty_image();
    set_image_size('0);
    repeat (4) send_byte(8'($urandom_range(255)));
    set_image_size(IMAGE_SIZE_RESET);
  endtask

  // Hand-built instructions over the length rules and the branch kinds
  task automatic test_branch_lengths();
    send_byte(OP_JMP_SHORT); send_byte(8'h00);        // forward to the next byte
    send_byte(OP_JMP_SHORT); send_byte(8'hFC);        // back to address zero
    send_byte(OP_JCC_LO + 8'h5); send_byte(8'h80);    // negative target, dropped
    send_byte(OP_CALL_NEAR); send_byte(8'hF8); send_byte(8'hFF);
    // group 3 TEST with direct address and byte immediate
    send_byte(OP_GRP3_B); send_byte(8'h06);
    send_byte(8'h34); send_byte(8'h12); send_byte(8'hAB);
    send_byte(OP_CALL_FAR);
    repeat (4) send_byte(8'h00);
    send_byte(OP_JMP_SHORT); send_byte(8'hEB);        // already marked target
    send_byte(OP_RET);
    send_byte(OP_JMP_NEAR); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'hFF);
  endtask

  // Branch instructions with random displacements, mixed with raw bytes
  task automatic test_random_stream(input int n);
    int sent;
    logic [7:0] op;
    logic [7:0] d8;
    logic [15:0] d16;
    sent = 0;
    while (sent < n) begin
      if (ph == PH_OPCODE && $urandom_range(99) < 40) begin
        case ($urandom_range(4))
          0: op = OP_JCC_LO + 8'($urandom_range(15));
          1: op = OP_LOOP_LO + 8'($urandom_range(3));
          2: op = OP_JMP_SHORT;
          3: op = OP_CALL_NEAR;
          default: op = OP_JMP_NEAR;
        endcase
        send_byte(op);
        if (op == OP_CALL_NEAR || op == OP_JMP_NEAR) begin
          d16 = 16'($urandom_range(65535));
          if ($urandom_range(1) == 1) d16 = 16'($urandom_range(128) - 64);
          send_byte(d16[7:0]);
          send_byte(d16[15:8]);
          sent += 3;
        end else begin
          d8 = 8'($urandom_range(255));
          if ($urandom_range(1) == 1) d8 = 8'($urandom_range(16) - 8);
          send_byte(d8);
          sent += 2;
        end
      end else begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  // Image ends a little ahead: partial instructions and far targets drop
  task automatic test_cut_image();
    int span;
    span = $urandom_range(180, 120);
    set_image_size(pos + SIZE_W'(span));
    test_random_stream(span);
    repeat (10) send_byte(8'($urandom_range(255)));
    set_image_size(IMAGE_SIZE_RESET);
  endtask

  // Size lowered below the position: bytes ignored until it is raised
  task automatic test_lowered_size();
    set_image_size(pos - POS_W'(1));
    repeat (8) send_byte(OP_JMP_SHORT);
    set_image_size(IMAGE_SIZE_RESET);
  endtask

  // End the image six bytes ahead and branch to its last byte and past it
  task automatic test_top_of_image();
    while (ph != PH_OPCODE) send_byte(OP_NOP);
    set_image_size(pos + SIZE_W'(6));
    send_byte(OP_JMP_SHORT); send_byte(8'h03);
    send_byte(OP_JMP_NEAR); send_byte(8'h01); send_byte(8'h00);
    send_byte(OP_JMP_SHORT); send_byte(8'h00); send_byte(8'h00);
    set_image_size(IMAGE_SIZE_RESET);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    code_if.valid     = 1'b0;
    code_if.code_byte = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 21;
    snk_idle_pct = 53;
    test_empty_image();
    test_branch_lengths();
    test_random_stream(250);

    src_idle_pct = 53;
    snk_idle_pct = 21;
    test_cut_image();
    test_random_stream(200);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_stream(250);
    test_lowered_size();
    test_top_of_image();

    settle();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
